// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the trace ring.
// Both expect a clock named clk and an active-low reset named arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Antecedent in one cycle implies the consequent in the next one.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/otrb_pkg.sv
// ----------------------------------------------------------------------------
// otrb_pkg
// Types, codes and field layouts of the overwriting trace ring.
// ----------------------------------------------------------------------------
package otrb_pkg;

	// Field widths
	localparam int KIND_W     = 3;
	localparam int LVL_W      = 3;
	localparam int CPU_W      = 4;
	localparam int STAMP_W    = 32;
	localparam int PAY_W      = 32;
	localparam int IDX_W      = 8;
	localparam int MAXC_W     = 7;
	localparam int POS_W      = 6;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 80;
	localparam int DEPTH_DEF  = 64;

	// Signed width used for the range bound arithmetic
	localparam int RNG_W = IDX_W + 2;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		K_FILT  = 3'd0,
		K_FORCE = 3'd1,
		K_POP   = 3'd2,
		K_DRAIN = 3'd3,
		K_RANGE = 3'd4,
		K_CLEAR = 3'd5
	} kind_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		RS_REC    = 2'd0,
		RS_ECHO   = 2'd1,
		RS_EMPTY  = 2'd2,
		RS_BADARG = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STORE = 2'd0,
		CFG_ECHO  = 2'd1,
		CFG_LIMIT = 2'd2
	} cfg_idx_t;

	// Request payload on s_tdata, last field in the lowest bits
	typedef struct packed {
		logic [1:0]              pad;
		logic [MAXC_W-1:0]       max_count;
		logic signed [IDX_W-1:0] final_index;
		logic signed [IDX_W-1:0] first_index;
		logic [PAY_W-1:0]        payload;
		logic [STAMP_W-1:0]      stamp;
		logic [CPU_W-1:0]        cpu_id;
		logic [LVL_W-1:0]        level;
	} req_t;

	// Result payload on m_tdata
	typedef struct packed {
		logic [2:0]         pad;
		logic [POS_W-1:0]   position;
		logic [PAY_W-1:0]   payload_res;
		logic [STAMP_W-1:0] stamp_res;
		logic [CPU_W-1:0]   cpu_id_res;
		logic [LVL_W-1:0]   level_res;
	} res_t;

	// Record metadata word as kept in memory
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [CPU_W-1:0]   cpu_id;
		logic [LVL_W-1:0]   level;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	function automatic res_t pack_result(input meta_t meta, input logic [PAY_W-1:0] pay,
		input logic [POS_W-1:0] pos);
		res_t r;
		r.pad         = '0;
		r.position    = pos;
		r.payload_res = pay;
		r.stamp_res   = meta.stamp;
		r.cpu_id_res  = meta.cpu_id;
		r.level_res   = meta.level;
		return r;
	endfunction

endpackage

// File: rtl/otrb_ram.sv
// ----------------------------------------------------------------------------
// otrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module otrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/overwriting_trace_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer_top
// Trace ring of DEPTH log records that overwrites the oldest record when full.
// ----------------------------------------------------------------------------
// One request at a time. A write without echo or a clear is accepted, then
// does its memory write and pointer update. An echoing write or a
// status-only answer is accepted, then does its write or its status check, and
// then loads its result into the output register once that register is free.
// Pop, drain and range read first run their setup (accept, bound and count
// computation, first memory read) and then hand out one record per cycle while
// m_tready is high: the single read port of the record memories sets that
// pace. The next request is taken after the last record of a run. A request
// may be accepted while the last result of the previous one still sits in the
// output register. The record memories are not cleared after reset and need
// no clearing pass; the block takes requests right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module overwriting_trace_ring_buffer_top import otrb_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// level, cpu_id, stamp, payload, first_index, final_index, max_count, 2 pad bits
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// kind
	input  logic [KIND_W-1:0]     s_tuser,
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// level_res, cpu_id_res, stamp_res, payload_res, position, 3 pad bits
	output logic [M_TDATA_W-1:0]  m_tdata,
	// status
	output logic [STAT_W-1:0]     m_tuser,
	output logic                  m_tlast
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RD,
		ST_LD,
		ST_SGL
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       wp_q, rp_q, rd_addr_q, pos_q;
	logic [CW-1:0]       held_q, left_q;
	logic                store_en_q, echo_en_q;
	logic [LVL_W-1:0]    lvl_lim_q;
	logic [KIND_W-1:0]   kind_q;
	req_t                req_q;
	res_t                sgl_data_q;
	logic [STAT_W-1:0]   sgl_user_q;
	logic                m_tvalid_q, m_tlast_q;
	res_t                m_tdata_q;
	logic [STAT_W-1:0]   m_tuser_q;

	logic                out_free, out_load, wr_ok, run_last;
	logic [AW-1:0]       addr_next, rng_start, run_start, echo_pos, wp_chk;
	logic [CW-1:0]       drain_cnt, rng_cnt, run_cnt;
	logic signed [RNG_W-1:0] hc_s, s_v, e_v, t_v, c_v, max_s;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_raddr;
	meta_t               meta_wdata, meta_rdata;
	logic [PAY_W-1:0]    pay_rdata;

	// (a + b) mod DEPTH with a < DEPTH and b <= DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
		input logic [CW-1:0] b);
		logic [CW:0] sum;
		sum = (CW+1)'(a) + (CW+1)'(b);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && ((state_q == ST_LD) || (state_q == ST_SGL));
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign wp_chk   = wrap_add(rp_q, held_q);

	// Record memories
	assign meta_wdata = '{stamp: req_q.stamp, cpu_id: req_q.cpu_id, level: req_q.level};

	otrb_ram #(.WIDTH(META_W), .DEPTH(DEPTH)) u_meta_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (meta_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (meta_rdata)
	);

	otrb_ram #(.WIDTH(PAY_W), .DEPTH(DEPTH)) u_pay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (req_q.payload),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (pay_rdata)
	);

	// Write filter and memory control
	always_comb begin
		wr_ok = (kind_q == K_FORCE) || ((kind_q == K_FILT) && (req_q.level <= lvl_lim_q));
		ram_we = (state_q == ST_PREP) && wr_ok;
		run_last = (left_q == CW'(1));
		addr_next = wrap_add(rd_addr_q, CW'(1));
		ram_re = (state_q == ST_RD) || ((state_q == ST_LD) && out_free && !run_last);
		ram_raddr = (state_q == ST_RD) ? rd_addr_q : addr_next;
	end

	// Echo position: distance of the written slot from the read pointer after the write
	always_comb begin
		if (store_en_q) begin
			echo_pos = (held_q == CW'(DEPTH)) ? AW'(DEPTH - 1) : held_q[AW-1:0];
		end else begin
			echo_pos = (held_q == CW'(DEPTH)) ? '0 : held_q[AW-1:0];
		end
	end

	// Drain count
	always_comb begin
		if (MAXC_W'(held_q) < req_q.max_count) begin
			drain_cnt = held_q;
		end else begin
			drain_cnt = req_q.max_count[CW-1:0];
		end
	end

	// Range bounds; only used with a non-empty ring
	always_comb begin
		hc_s  = $signed(RNG_W'(held_q));
		max_s = $signed(RNG_W'(req_q.max_count));
		s_v   = RNG_W'($signed(req_q.first_index));
		e_v   = RNG_W'($signed(req_q.final_index));
		if (s_v < 0) begin
			s_v = hc_s + s_v;
			if (s_v < 0) begin
				s_v = '0;
			end
		end
		if (e_v < 0) begin
			e_v = hc_s + e_v;
			if (e_v < 0) begin
				e_v = '0;
			end
		end
		if ($signed(req_q.first_index) < 0 && req_q.final_index == '0) begin
			e_v = hc_s - RNG_W'(1);
		end
		if (s_v >= hc_s) begin
			s_v = hc_s - RNG_W'(1);
		end
		if (e_v >= hc_s) begin
			e_v = hc_s - RNG_W'(1);
		end
		t_v = s_v;
		if (s_v > e_v) begin
			s_v = e_v;
			e_v = t_v;
		end
		c_v = e_v - s_v + RNG_W'(1);
		if (c_v > max_s) begin
			c_v = max_s;
		end
		rng_start = s_v[AW-1:0];
		rng_cnt   = c_v[CW-1:0];
	end

	// Run setup for pop, drain and range read
	always_comb begin
		if (kind_q == K_RANGE) begin
			run_start = rng_start;
			run_cnt   = rng_cnt;
		end else if (kind_q == K_DRAIN) begin
			run_start = '0;
			run_cnt   = drain_cnt;
		end else begin
			run_start = '0;
			run_cnt   = CW'(1);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_en_q <= 1'b1;
			echo_en_q  <= 1'b1;
			lvl_lim_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STORE: store_en_q <= cfg_data[0];
				CFG_ECHO:  echo_en_q  <= cfg_data[0];
				CFG_LIMIT: lvl_lim_q  <= cfg_data[LVL_W-1:0];
				default:   ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			req_q  <= req_t'(s_tdata);
		end
	end

	// Sequencer, ring pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			rp_q       <= '0;
			held_q     <= '0;
			rd_addr_q  <= '0;
			pos_q      <= '0;
			left_q     <= '0;
			sgl_data_q <= '0;
			sgl_user_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					unique case (kind_q)
						K_FILT, K_FORCE: begin
							if (wr_ok && echo_en_q) begin
								state_q <= ST_SGL;
							end else begin
								state_q <= ST_IDLE;
							end
							if (wr_ok) begin
								if (store_en_q) begin
									wp_q <= wrap_add(wp_q, CW'(1));
									if (held_q != CW'(DEPTH)) begin
										held_q <= held_q + CW'(1);
									end else begin
										rp_q <= wrap_add(rp_q, CW'(1));
									end
								end
								if (echo_en_q) begin
									sgl_data_q <= pack_result(meta_wdata, req_q.payload,
										POS_W'(echo_pos));
									sgl_user_q <= RS_ECHO;
								end
							end
						end
						K_POP, K_DRAIN, K_RANGE: begin
							if (kind_q != K_POP && req_q.max_count == '0) begin
								sgl_data_q <= '0;
								sgl_user_q <= RS_BADARG;
								state_q    <= ST_SGL;
							end else if (held_q == '0) begin
								sgl_data_q <= '0;
								sgl_user_q <= RS_EMPTY;
								state_q    <= ST_SGL;
							end else begin
								rd_addr_q <= wrap_add(rp_q, CW'(run_start));
								pos_q     <= run_start;
								left_q    <= run_cnt;
								if (kind_q != K_RANGE) begin
									rp_q   <= wrap_add(rp_q, run_cnt);
									held_q <= held_q - run_cnt;
								end
								state_q <= ST_RD;
							end
						end
						K_CLEAR: begin
							wp_q    <= '0;
							rp_q    <= '0;
							held_q  <= '0;
							state_q <= ST_IDLE;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (out_free) begin
						m_tdata_q  <= pack_result(meta_rdata, pay_rdata, POS_W'(pos_q));
						m_tuser_q  <= RS_REC;
						m_tlast_q  <= run_last;
						if (run_last) begin
							state_q <= ST_IDLE;
						end else begin
							left_q    <= left_q - CW'(1);
							pos_q     <= pos_q + AW'(1);
							rd_addr_q <= addr_next;
						end
					end
				end
				ST_SGL: begin
					if (out_free) begin
						m_tdata_q  <= sgl_data_q;
						m_tuser_q  <= sgl_user_q;
						m_tlast_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	`CHK_ALWAYS(a_held_bound, held_q <= CW'(DEPTH), "held count above depth")
	`CHK_ALWAYS(a_ptr_invariant, wp_q == wp_chk, "write pointer out of step with read pointer")
	`CHK_ALWAYS(a_no_rw_overlap, !(ram_we && ram_re), "memory read and write in one cycle")
	`CHK_ALWAYS(a_run_nonempty, state_q != ST_LD || left_q != '0, "record run with no records")
	`CHK_NEXT(a_run_end, state_q == ST_LD && out_free && run_last, m_tvalid_q && m_tlast_q && state_q == ST_IDLE, "run end not marked")

endmodule
